@@ rtl/huffman_tree_walk_decoder_macros.svh @@
// Assertion macros used by the decoder's top level.
// No dependencies; included by the top level.
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

// Property that must hold in the same cycle as its condition.
`define HTWD_ASSERT_IMPLY(name, clk_s, rst_s, cond, prop) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Property that must hold in the cycle after its condition.
`define HTWD_ASSERT_NEXT(name, clk_s, rst_s, cond, prop) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/htwd_pkg.sv @@
// Shared constants and codes for the Huffman tree-walk decoder.
// No dependencies; used by the front end, back end and top level.
`timescale 1ns / 1ps

package htwd_pkg;

  localparam int FIELD_IDX_W = 9;
  localparam int SYM_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_INDEX = 1'b0,
    CFG_LAST_BITS  = 1'b1
  } cfg_reg_t;

endpackage

@@ rtl/htwd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the node table.
`timescale 1ns / 1ps

module htwd_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/htwd_fifo.sv @@
// Short register queue between the front end and the back end.
// No dependencies.
`timescale 1ns / 1ps

module htwd_fifo #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/htwd_front.sv @@
// Front end: configuration registers, item intake and index wrapping.
// Depends on htwd_pkg; feeds the queue toward htwd_back.
`timescale 1ns / 1ps

module htwd_front #(
  parameter int NODE_COUNT = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 func,
  input  logic [htwd_pkg::FIELD_IDX_W-1:0]     node_index,
  input  logic                                 node_is_leaf,
  input  logic [htwd_pkg::SYM_W-1:0]           node_symbol,
  input  logic [htwd_pkg::FIELD_IDX_W-1:0]     left_child,
  input  logic [htwd_pkg::FIELD_IDX_W-1:0]     right_child,
  input  logic                                 right_present,
  input  logic [htwd_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                 last_byte,
  input  logic                                 cfg_we,
  input  logic [htwd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [htwd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 q_full,
  output logic                                 q_push,
  output logic [3*$clog2(NODE_COUNT)+24-1:0]   q_entry,
  output logic [$clog2(NODE_COUNT)-1:0]        root,
  output logic                                 root_load
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int SPAN  = 1 << htwd_pkg::FIELD_IDX_W;

  logic [htwd_pkg::CNT_W-1:0] last_bits;
  logic [htwd_pkg::CNT_W-1:0] nbits;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [htwd_pkg::FIELD_IDX_W-1:0] v);
    logic [htwd_pkg::FIELD_IDX_W:0] r;
    r = {1'b0, v};
    for (int k = htwd_pkg::FIELD_IDX_W - 1; k >= 0; k--) begin
      if ((NODE_COUNT << k) < SPAN) begin
        if (r >= (htwd_pkg::FIELD_IDX_W + 1)'(NODE_COUNT << k)) begin
          r = r - (htwd_pkg::FIELD_IDX_W + 1)'(NODE_COUNT << k);
        end
      end
    end
    return IDX_W'(r);
  endfunction

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    nbits = htwd_pkg::BITS_PER_BYTE;
    if (last_byte) begin
      nbits = (last_bits > htwd_pkg::BITS_PER_BYTE) ? htwd_pkg::BITS_PER_BYTE : last_bits;
    end
  end

  assign q_entry = {func, wrap_idx(node_index),
                    node_is_leaf, node_symbol, wrap_idx(left_child), wrap_idx(right_child),
                    right_present, data_byte, nbits, last_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      root      <= '0;
      last_bits <= htwd_pkg::BITS_PER_BYTE;
      root_load <= 1'b0;
    end else begin
      root_load <= cfg_we && (cfg_index == htwd_pkg::CFG_ROOT_INDEX);
      if (cfg_we && (cfg_index == htwd_pkg::CFG_ROOT_INDEX)) begin
        root <= wrap_idx(cfg_data[htwd_pkg::FIELD_IDX_W-1:0]);
      end
      if (cfg_we && (cfg_index == htwd_pkg::CFG_LAST_BITS)) begin
        last_bits <= cfg_data[htwd_pkg::CNT_W-1:0];
      end
    end
  end

endmodule

@@ rtl/htwd_back.sv @@
// Back end: node table writes, the bit-by-bit tree walk and the result register.
// Depends on htwd_pkg; reads the queue and drives the node table RAM.
`timescale 1ns / 1ps

module htwd_back #(
  parameter int IDX_W = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  logic [3*IDX_W+24-1:0]          q_entry,
  output logic                           q_pop,
  input  logic [IDX_W-1:0]               root,
  input  logic                           root_load,
  output logic                           ram_we,
  output logic [IDX_W-1:0]               ram_waddr,
  output logic [2*IDX_W+10-1:0]          ram_wdata,
  output logic                           ram_re,
  output logic [IDX_W-1:0]               ram_raddr,
  input  logic [2*IDX_W+10-1:0]          ram_rdata,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [htwd_pkg::SYM_W-1:0]     symbol,
  output logic                           error,
  output logic                           last
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FLUSH} state_t;

  state_t state, state_next;

  logic                          q_func;
  logic [IDX_W-1:0]              q_idx;
  logic [2*IDX_W+10-1:0]         q_node;
  logic [htwd_pkg::BYTE_W-1:0]   q_byte;
  logic [htwd_pkg::CNT_W-1:0]    q_nbits;
  logic                          q_last;

  logic                          n_leaf;
  logic [htwd_pkg::SYM_W-1:0]    n_sym;
  logic [IDX_W-1:0]              n_left;
  logic [IDX_W-1:0]              n_right;
  logic                          n_has_right;

  logic [IDX_W-1:0]              pos, pos_next;
  logic [htwd_pkg::BYTE_W-1:0]   byte_sr, byte_sr_next;
  logic [htwd_pkg::CNT_W-1:0]    bit_cnt, bit_cnt_next;
  logic [htwd_pkg::CNT_W-1:0]    nbits;
  logic                          is_last;
  logic                          arrived, arrived_next;
  logic                          held_valid, held_valid_next;
  logic [htwd_pkg::SYM_W-1:0]    held_sym, held_sym_next;
  logic                          held_err, held_err_next;

  logic                          load_byte;
  logic                          out_free;
  logic                          at_leaf;
  logic                          ev;
  logic [htwd_pkg::SYM_W-1:0]    ev_sym;
  logic                          ev_err;
  logic                          push;
  logic                          push_last;

  assign {q_func, q_idx, q_node, q_byte, q_nbits, q_last} = q_entry;
  assign {n_leaf, n_sym, n_left, n_right, n_has_right}   = ram_rdata;

  assign out_free = !result_valid || !result_stall;
  assign at_leaf  = arrived && n_leaf;

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    byte_sr_next    = byte_sr;
    bit_cnt_next    = bit_cnt;
    arrived_next    = arrived;
    held_valid_next = held_valid;
    held_sym_next   = held_sym;
    held_err_next   = held_err;
    q_pop           = 1'b0;
    load_byte       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = q_idx;
    ram_wdata       = q_node;
    ram_re          = 1'b0;
    ram_raddr       = pos;
    ev              = 1'b0;
    ev_sym          = '0;
    ev_err          = 1'b0;
    push            = 1'b0;
    push_last       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_func == htwd_pkg::FUNC_LOAD) begin
            ram_we = 1'b1;
          end else begin
            load_byte    = 1'b1;
            ram_re       = 1'b1;
            byte_sr_next = q_byte;
            bit_cnt_next = '0;
            arrived_next = 1'b0;
            state_next   = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (at_leaf) begin
          ev     = 1'b1;
          ev_sym = n_sym;
        end else if ((bit_cnt != nbits) && byte_sr[htwd_pkg::BYTE_W-1] && !n_has_right) begin
          ev     = 1'b1;
          ev_err = 1'b1;
        end
        if (!(ev && held_valid && !out_free)) begin
          if (ev) begin
            push            = held_valid;
            held_valid_next = 1'b1;
            held_sym_next   = ev_sym;
            held_err_next   = ev_err;
          end
          if (at_leaf) begin
            pos_next     = root;
            arrived_next = 1'b0;
            if (bit_cnt == nbits) begin
              state_next = S_FLUSH;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = root;
            end
          end else if (bit_cnt == nbits) begin
            state_next = S_FLUSH;
          end else begin
            bit_cnt_next = bit_cnt + 1'b1;
            byte_sr_next = {byte_sr[htwd_pkg::BYTE_W-2:0], 1'b0};
            ram_re       = 1'b1;
            priority if (!byte_sr[htwd_pkg::BYTE_W-1]) begin
              pos_next     = n_left;
              arrived_next = 1'b1;
              ram_raddr    = n_left;
            end else if (n_has_right) begin
              pos_next     = n_right;
              arrived_next = 1'b1;
              ram_raddr    = n_right;
            end else begin
              pos_next     = root;
              arrived_next = 1'b0;
              ram_raddr    = root;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!held_valid || out_free) begin
          push            = held_valid;
          push_last       = is_last;
          held_valid_next = 1'b0;
          if (is_last) begin
            pos_next = root;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (root_load) begin
      pos_next = root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      arrived      <= 1'b0;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pos        <= pos_next;
      arrived    <= arrived_next;
      held_valid <= held_valid_next;
      held_sym   <= held_sym_next;
      held_err   <= held_err_next;
      byte_sr    <= byte_sr_next;
      bit_cnt    <= bit_cnt_next;
      if (load_byte) begin
        nbits   <= q_nbits;
        is_last <= q_last;
      end
      if (push) begin
        result_valid <= 1'b1;
        symbol       <= held_sym;
        error        <= held_err;
        last         <= push_last;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/huffman_tree_walk_decoder.sv @@
// Order: a byte enters the queue on its transfer and leaves it once the back end is idle; each
// result is held until the next one or the end of its byte, then goes to the result register.
// Walk: one node-table read per bit step; no new item is taken until a byte is done, and the walk
// holds while a result waits on an output stall. A load item is written as it leaves the queue.
// Reset (synchronous, active high): root 0, 8 valid bits in a last byte, walk at node 0,
// queue and result register empty; the node table is not cleared.
`timescale 1ns / 1ps
`include "huffman_tree_walk_decoder_macros.svh"

module huffman_tree_walk_decoder #(
  parameter int NODE_COUNT = 512
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               func,
  input  logic [htwd_pkg::FIELD_IDX_W-1:0]   node_index,
  input  logic                               node_is_leaf,
  input  logic [htwd_pkg::SYM_W-1:0]         node_symbol,
  input  logic [htwd_pkg::FIELD_IDX_W-1:0]   left_child,
  input  logic [htwd_pkg::FIELD_IDX_W-1:0]   right_child,
  input  logic                               right_present,
  input  logic [htwd_pkg::BYTE_W-1:0]        data_byte,
  input  logic                               last_byte,
  input  logic                               cfg_we,
  input  logic [htwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [htwd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [htwd_pkg::SYM_W-1:0]         symbol,
  output logic                               error,
  output logic                               last
);

  localparam int IDX_W   = $clog2(NODE_COUNT);
  localparam int NODE_W  = 2 * IDX_W + 10;
  localparam int ENTRY_W = 3 * IDX_W + 24;

  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_push_data;
  logic [ENTRY_W-1:0] q_pop_data;
  logic [IDX_W-1:0]   root;
  logic               root_load;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [NODE_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [NODE_W-1:0]  ram_rdata;

  htwd_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .node_index   (node_index),
    .node_is_leaf (node_is_leaf),
    .node_symbol  (node_symbol),
    .left_child   (left_child),
    .right_child  (right_child),
    .right_present(right_present),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_push_data),
    .root         (root),
    .root_load    (root_load)
  );

  htwd_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(htwd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  htwd_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODE_COUNT)
  ) u_node_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  htwd_back #(
    .IDX_W(IDX_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_entry     (q_pop_data),
    .q_pop       (q_pop),
    .root        (root),
    .root_load   (root_load),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .symbol      (symbol),
    .error       (error),
    .last        (last)
  );

  `HTWD_ASSERT_IMPLY(a_pop_has_entry, clk, rst, q_pop, !q_empty)
  `HTWD_ASSERT_NEXT(a_push_fills_queue, clk, rst, q_push && !q_pop, !q_empty)
  `HTWD_ASSERT_IMPLY(a_table_write_alone, clk, rst, ram_we, !ram_re)
  `HTWD_ASSERT_IMPLY(a_error_zero_symbol, clk, rst, result_valid && error, symbol == '0)

endmodule

@@ verif/tb.sv @@
// Testbench for huffman_tree_walk_decoder: loads code trees, decodes bytes, and checks every
// decoded symbol against a tree walk that it keeps itself.
// Depends on htwd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic                             leaf;
    logic [htwd_pkg::SYM_W-1:0]       sym;
    logic [htwd_pkg::FIELD_IDX_W-1:0] left;
    logic [htwd_pkg::FIELD_IDX_W-1:0] right;
    logic                             has_right;
  } tree_node_t;

  typedef struct {
    htwd_pkg::func_t                  func;
    logic [htwd_pkg::FIELD_IDX_W-1:0] node_index;
    logic                             node_is_leaf;
    logic [htwd_pkg::SYM_W-1:0]       node_symbol;
    logic [htwd_pkg::FIELD_IDX_W-1:0] left_child;
    logic [htwd_pkg::FIELD_IDX_W-1:0] right_child;
    logic                             right_present;
    logic [htwd_pkg::BYTE_W-1:0]      data_byte;
    logic                             last_byte;
  } tree_item_t;

  typedef struct {
    logic [htwd_pkg::SYM_W-1:0] sym;
    logic                       err;
    logic                       last;
  } tree_result_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             item_valid = 1'b0;
  logic                             item_stall;
  htwd_pkg::func_t                  func = htwd_pkg::FUNC_LOAD;
  logic [htwd_pkg::FIELD_IDX_W-1:0] node_index = '0;
  logic                             node_is_leaf = 1'b0;
  logic [htwd_pkg::SYM_W-1:0]       node_symbol = '0;
  logic [htwd_pkg::FIELD_IDX_W-1:0] left_child = '0;
  logic [htwd_pkg::FIELD_IDX_W-1:0] right_child = '0;
  logic                             right_present = 1'b0;
  logic [htwd_pkg::BYTE_W-1:0]      data_byte = '0;
  logic                             last_byte = 1'b0;
  logic                             cfg_we = 1'b0;
  htwd_pkg::cfg_reg_t               cfg_index = htwd_pkg::CFG_ROOT_INDEX;
  logic [htwd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [htwd_pkg::SYM_W-1:0]       symbol;
  logic                             error;
  logic                             last;

  huffman_tree_walk_decoder uut (.*);

  tree_node_t                       node_mem [512];
  logic [htwd_pkg::FIELD_IDX_W-1:0] walk_pos = '0;
  logic [htwd_pkg::FIELD_IDX_W-1:0] model_root = '0;
  logic [htwd_pkg::CNT_W-1:0]       model_last_bits = htwd_pkg::BITS_PER_BYTE;

  tree_item_t                       pending_items[$];
  tree_result_t                     expected_symbols[$];
  tree_item_t                       cur_item;
  bit                               node_loaded [512];
  logic [htwd_pkg::FIELD_IDX_W-1:0] loaded_list[$];
  int                               stim_count = 0;
  int                               fail_count = 0;
  int                               burst_left = 4;
  int                               gap_left = 0;
  int                               stall_mode = 0;
  int                               stall_timer = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    fail_count++;
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
  endtask

  function automatic void walk_tree(input tree_item_t it);
    int         i;
    int         nbits;
    int         got;
    logic       stepped;
    tree_node_t cur;
    if (it.func == htwd_pkg::FUNC_LOAD) begin
      node_mem[it.node_index] = {it.node_is_leaf, it.node_symbol, it.left_child,
                                 it.right_child, it.right_present};
    end else begin
      nbits = int'(htwd_pkg::BITS_PER_BYTE);
      if (it.last_byte)
        nbits = (model_last_bits > htwd_pkg::BITS_PER_BYTE) ?
                int'(htwd_pkg::BITS_PER_BYTE) : int'(model_last_bits);
      got = 0;
      for (i = 0; i < nbits; i++) begin
        cur = node_mem[walk_pos];
        stepped = 1'b1;
        if (!it.data_byte[htwd_pkg::BYTE_W-1-i]) begin
          walk_pos = cur.left;
        end else if (cur.has_right) begin
          walk_pos = cur.right;
        end else begin
          expected_symbols.insert(expected_symbols.size(),
                                  tree_result_t'{sym: '0, err: 1'b1, last: 1'b0});
          got++;
          walk_pos = model_root;
          stepped = 1'b0;
        end
        if (stepped && node_mem[walk_pos].leaf) begin
          expected_symbols.insert(expected_symbols.size(),
                                  tree_result_t'{sym: node_mem[walk_pos].sym, err: 1'b0,
                                                 last: 1'b0});
          got++;
          walk_pos = model_root;
        end
      end
      if (it.last_byte) begin
        walk_pos = model_root;
        if (got > 0) expected_symbols[expected_symbols.size()-1].last = 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) walk_tree(cur_item);
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          item_valid    <= 1'b1;
          func          <= cur_item.func;
          node_index    <= cur_item.node_index;
          node_is_leaf  <= cur_item.node_is_leaf;
          node_symbol   <= cur_item.node_symbol;
          left_child    <= cur_item.left_child;
          right_child   <= cur_item.right_child;
          right_present <= cur_item.right_present;
          data_byte     <= cur_item.data_byte;
          last_byte     <= cur_item.last_byte;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode = $urandom_range(3);
      stall_timer = $urandom_range(20, 120);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(2) == 0);
      2: result_stall <= ($urandom_range(3) != 0);
      default: result_stall <= stall_timer[2];
    endcase
    if (!rst && result_valid && !result_stall) begin : check_result
      tree_result_t want;
      if (expected_symbols.size() == 0) begin
        report_mismatch("result with none pending", 0, 32'(symbol));
      end else begin
        want = expected_symbols.pop_front();
        if (symbol !== want.sym) report_mismatch("symbol", 32'(want.sym), 32'(symbol));
        if (error !== want.err) report_mismatch("error", 32'(want.err), 32'(error));
        if (last !== want.last) report_mismatch("last", 32'(want.last), 32'(last));
      end
    end
  end

  function automatic logic [htwd_pkg::FIELD_IDX_W-1:0] pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  function automatic void queue_load(input logic [htwd_pkg::FIELD_IDX_W-1:0] idx,
                                     input bit leaf,
                                     input logic [htwd_pkg::SYM_W-1:0] sym,
                                     input logic [htwd_pkg::FIELD_IDX_W-1:0] l,
                                     input logic [htwd_pkg::FIELD_IDX_W-1:0] r,
                                     input bit rp);
    tree_item_t it;
    it.func = htwd_pkg::FUNC_LOAD;
    it.node_index = idx;
    it.node_is_leaf = leaf;
    it.node_symbol = sym;
    it.left_child = l;
    it.right_child = r;
    it.right_present = rp;
    it.data_byte = 8'($urandom_range(255));
    it.last_byte = 1'($urandom_range(1));
    pending_items.insert(pending_items.size(), it);
    stim_count++;
    if (!node_loaded[idx]) begin
      node_loaded[idx] = 1'b1;
      loaded_list.insert(loaded_list.size(), idx);
    end
  endfunction

  function automatic void queue_decode(input logic [htwd_pkg::BYTE_W-1:0] data, input bit fin);
    tree_item_t it;
    it.func = htwd_pkg::FUNC_DECODE;
    it.node_index = 9'($urandom_range(511));
    it.node_is_leaf = 1'($urandom_range(1));
    it.node_symbol = 8'($urandom_range(255));
    it.left_child = 9'($urandom_range(511));
    it.right_child = 9'($urandom_range(511));
    it.right_present = 1'($urandom_range(1));
    it.data_byte = data;
    it.last_byte = fin;
    pending_items.insert(pending_items.size(), it);
    stim_count++;
  endfunction

  // Children are loaded before their parent, so every node reachable by a walk is written.
  function automatic logic [htwd_pkg::FIELD_IDX_W-1:0] grow_subtree(input int depth,
                                                                   input int max_depth);
    logic [htwd_pkg::FIELD_IDX_W-1:0] idx;
    logic [htwd_pkg::FIELD_IDX_W-1:0] l;
    logic [htwd_pkg::FIELD_IDX_W-1:0] r;
    bit                               rp;
    idx = 9'($urandom_range(511));
    if (depth >= max_depth || (depth > 0 && $urandom_range(99) < 35)) begin
      l = (loaded_list.size() != 0 && $urandom_range(1)) ? pick_loaded() : idx;
      r = (loaded_list.size() != 0 && $urandom_range(1)) ? pick_loaded() : idx;
      queue_load(idx, 1'b1, 8'($urandom_range(255)), l, r, 1'($urandom_range(1)));
    end else begin
      l = grow_subtree(depth + 1, max_depth);
      rp = ($urandom_range(99) < 85);
      r = rp ? grow_subtree(depth + 1, max_depth) : 9'($urandom_range(511));
      queue_load(idx, 1'b0, 8'($urandom_range(255)), l, r, rp);
    end
    return idx;
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_symbols.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic cfg_write(input htwd_pkg::cfg_reg_t idx,
                           input logic [htwd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == htwd_pkg::CFG_ROOT_INDEX) begin
      model_root = val;
      walk_pos = val;
    end else begin
      model_last_bits = val[htwd_pkg::CNT_W-1:0];
    end
    @(negedge clk);
  endtask

  initial begin
    logic [htwd_pkg::FIELD_IDX_W-1:0] tree_root;
    bit                               rp_flag;
    int                               n;
    int                               r;
    logic [htwd_pkg::CNT_W-1:0]       lb;
    logic [htwd_pkg::CFG_DATA_W-1:0]  val;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_load(9'd1, 1'b1, 8'h00, 9'd1, 9'd1, 1'b0);
    queue_load(9'd511, 1'b1, 8'hFF, 9'd511, 9'd511, 1'b1);
    queue_load(9'd0, 1'b0, 8'h5A, 9'd1, 9'd511, 1'b1);
    queue_decode(8'h00, 1'b0);
    queue_decode(8'hFF, 1'b0);
    queue_load(9'd2, 1'b0, 8'hA5, 9'd1, 9'h1AA, 1'b0);
    queue_load(9'd0, 1'b0, 8'h5A, 9'd2, 9'd511, 1'b1);
    queue_decode(8'h40, 1'b0);
    queue_decode(8'h80, 1'b0);
    queue_load(9'd3, 1'b1, 8'h33, 9'd1, 9'd1, 1'b1);
    queue_decode(8'h7F, 1'b0);
    queue_decode(8'h3C, 1'b1);
    queue_decode(8'h00, 1'b1);
    drain();
    cfg_write(htwd_pkg::CFG_LAST_BITS, 9'd3);
    queue_decode(8'hE0, 1'b1);
    queue_decode(8'h20, 1'b1);
    queue_decode(8'h00, 1'b1);
    queue_decode(8'hFF, 1'b0);
    drain();
    cfg_write(htwd_pkg::CFG_LAST_BITS, 9'd0);
    queue_decode(8'hFF, 1'b1);
    queue_decode(8'h80, 1'b0);
    drain();
    cfg_write(htwd_pkg::CFG_ROOT_INDEX, 9'd511);
    cfg_write(htwd_pkg::CFG_LAST_BITS, 9'd15);
    queue_decode(8'h5A, 1'b1);
    drain();
    cfg_write(htwd_pkg::CFG_ROOT_INDEX, 9'd1);
    queue_decode(8'h96, 1'b0);
    drain();
    cfg_write(htwd_pkg::CFG_ROOT_INDEX, 9'd0);
    cfg_write(htwd_pkg::CFG_LAST_BITS, 9'd8);
    queue_decode(8'hC3, 1'b0);

    while (stim_count < 345) begin
      tree_root = grow_subtree(0, $urandom_range(1, 5));
      drain();
      if ($urandom_range(3) != 0) cfg_write(htwd_pkg::CFG_ROOT_INDEX, tree_root);
      else cfg_write(htwd_pkg::CFG_ROOT_INDEX, pick_loaded());
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0: lb = '0;
          1: lb = htwd_pkg::BITS_PER_BYTE;
          2: lb = 4'd15;
          default: lb = 4'($urandom_range(15));
        endcase
        val = {5'($urandom_range(31)), lb};
        cfg_write(htwd_pkg::CFG_LAST_BITS, val);
      end
      n = $urandom_range(8, 40);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 8) begin
          rp_flag = 1'($urandom_range(1));
          queue_load(9'($urandom_range(511)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                     pick_loaded(), rp_flag ? pick_loaded() : 9'($urandom_range(511)),
                     rp_flag);
        end else begin
          queue_decode(8'($urandom_range(255)), r < 20);
        end
      end
    end
    drain();
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/htwd_pkg.sv
rtl/htwd_ram.sv
rtl/htwd_fifo.sv
rtl/htwd_front.sv
rtl/htwd_back.sv
rtl/huffman_tree_walk_decoder.sv
verif/tb.sv
